// ===== design/ctm_pkg.sv =====
// Shared types, constants and a helper function for the color tolerance match counter.
`timescale 1ns / 1ps
package ctm_pkg;

  localparam int MAX_ROWS   = 4096;
  localparam int MAX_COLS   = 4096;
  localparam int NUM_COLORS = 5;

  localparam int DIM_W      = 13;
  localparam int ROW_IDX_W  = $clog2(MAX_ROWS);
  localparam int COL_IDX_W  = $clog2(MAX_COLS);
  localparam int PROD_W     = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int STEP_W     = $clog2(PROD_W);
  localparam int STRIDE_W   = 25;
  localparam int MATCH_W    = 27;
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 3 * CH_W;
  localparam int TOL_W      = 8;
  localparam int LIM_W      = TOL_W + 2;
  localparam int BUDGET_W   = 16;
  localparam int ACT_W      = 3;
  localparam int CNT_W      = $clog2(NUM_COLORS + 1);
  localparam int CFG_W      = 48;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CH_W-1:0] WIDE_HI  = CH_W'(230);
  localparam logic [CH_W-1:0] WIDE_MID = CH_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAIR_A  = 3'd0,
    REG_PAIR_B  = 3'd1,
    REG_LAST    = 3'd2,
    REG_ACTIVE  = 3'd3,
    REG_TOL     = 3'd4,
    REG_BUDGET  = 3'd5,
    REG_ROWS    = 3'd6,
    REG_COLS    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [MATCH_W-1:0]  match_count;
    logic [STRIDE_W-1:0] sample_denominator;
  } res_t;

  typedef logic [NUM_COLORS-1:0][COLOR_W-1:0] color_set_t;

  typedef struct packed {
    logic                busy;
    logic [STRIDE_W-1:0] stride;
    logic [STRIDE_W-1:0] denom;
  } stride_info_t;

  typedef struct packed {
    pix_t                pix;
    logic                sample;
    logic                last;
    logic [STRIDE_W-1:0] denom;
  } item_t;

  function automatic logic channel_ok(input logic [CH_W-1:0] refc,
                                      input logic [CH_W-1:0] pixc,
                                      input logic [TOL_W-1:0] tol);
    logic [CH_W-1:0]  diff;
    logic [LIM_W-1:0] lim;
    diff = (refc > pixc) ? refc - pixc : pixc - refc;
    if (refc > WIDE_HI) begin
      lim = {tol, 2'b00};
    end else if (refc > WIDE_MID) begin
      lim = LIM_W'(tol) + {1'b0, tol, 1'b0};
    end else begin
      lim = LIM_W'(tol);
    end
    return LIM_W'(diff) <= lim;
  endfunction

endpackage

// ===== design/ctm_stride.sv =====
// Stride and denominator engine: one multiply, then two bit-serial divisions (only the second when budget is 0).
`timescale 1ns / 1ps
module ctm_stride (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic [ctm_pkg::DIM_W-1:0]    rows,
  input  logic [ctm_pkg::DIM_W-1:0]    cols,
  input  logic [ctm_pkg::BUDGET_W-1:0] budget,
  output ctm_pkg::stride_info_t        info
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV1 = 4'b0100,
    ST_DIV2 = 4'b1000
  } st_t;

  st_t                            state_r, state_nxt;
  logic [ctm_pkg::STEP_W-1:0]     cnt_r, cnt_nxt;
  logic [ctm_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  logic [ctm_pkg::PROD_W-1:0]     dvd_r, dvd_nxt;
  logic [ctm_pkg::PROD_W-1:0]     quo_r, quo_nxt;
  logic [ctm_pkg::STRIDE_W-1:0]   div_r, div_nxt;
  logic [ctm_pkg::STRIDE_W-1:0]   rem_r, rem_nxt;
  logic [ctm_pkg::STRIDE_W-1:0]   stride_r, stride_nxt;
  logic [ctm_pkg::STRIDE_W-1:0]   denom_r, denom_nxt;

  logic [2*ctm_pkg::DIM_W-1:0]    mul;
  logic [ctm_pkg::STRIDE_W:0]     rem_sh;
  logic [ctm_pkg::STRIDE_W:0]     rem_sub;
  logic                           ge;
  logic [ctm_pkg::PROD_W-1:0]     step_quo;
  logic [ctm_pkg::STRIDE_W-1:0]   step_rem;
  logic                           last_step;
  logic [ctm_pkg::STRIDE_W-1:0]   q_plus;

  assign mul       = rows * cols;
  assign rem_sh    = {rem_r, dvd_r[ctm_pkg::PROD_W-1]};
  assign ge        = rem_sh >= {1'b0, div_r};
  assign rem_sub   = rem_sh - {1'b0, div_r};
  assign step_rem  = ge ? rem_sub[ctm_pkg::STRIDE_W-1:0] : rem_sh[ctm_pkg::STRIDE_W-1:0];
  assign step_quo  = {quo_r[ctm_pkg::PROD_W-2:0], ge};
  assign last_step = cnt_r == ctm_pkg::STEP_W'(ctm_pkg::PROD_W - 1);
  assign q_plus    = ctm_pkg::STRIDE_W'(step_quo) + ctm_pkg::STRIDE_W'(1);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    dvd_nxt    = dvd_r;
    quo_nxt    = quo_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    stride_nxt = stride_r;
    denom_nxt  = denom_r;
    case (state_r)
      ST_IDLE: begin
      end
      ST_MUL: begin
        prod_nxt = mul[ctm_pkg::PROD_W-1:0];
        dvd_nxt  = mul[ctm_pkg::PROD_W-1:0];
        quo_nxt  = '0;
        rem_nxt  = '0;
        cnt_nxt  = '0;
        if (budget == '0) begin
          stride_nxt = ctm_pkg::STRIDE_W'(1);
          div_nxt    = ctm_pkg::STRIDE_W'(1);
          state_nxt  = ST_DIV2;
        end else begin
          div_nxt   = ctm_pkg::STRIDE_W'(budget);
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        dvd_nxt = {dvd_r[ctm_pkg::PROD_W-2:0], 1'b0};
        quo_nxt = step_quo;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r + ctm_pkg::STEP_W'(1);
        if (last_step) begin
          stride_nxt = q_plus;
          div_nxt    = q_plus;
          dvd_nxt    = prod_r;
          quo_nxt    = '0;
          rem_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = ST_DIV2;
        end
      end
      ST_DIV2: begin
        dvd_nxt = {dvd_r[ctm_pkg::PROD_W-2:0], 1'b0};
        quo_nxt = step_quo;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r + ctm_pkg::STEP_W'(1);
        if (last_step) begin
          denom_nxt = ctm_pkg::STRIDE_W'(step_quo);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_MUL;
      end
    endcase
    if (restart) begin
      state_nxt = ST_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_MUL;
      cnt_r    <= '0;
      stride_r <= ctm_pkg::STRIDE_W'(1);
      denom_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      stride_r <= stride_nxt;
      denom_r  <= denom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
  end

  assign info.busy   = (state_r != ST_IDLE) || restart;
  assign info.stride = stride_r;
  assign info.denom  = denom_r;

endmodule

// ===== design/ctm_scan.sv =====
// Raster position tracking, sample selection and the input request register.
`timescale 1ns / 1ps
module ctm_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ctm_pkg::pix_t             in_data,
  input  logic [ctm_pkg::DIM_W-1:0] rows,
  input  logic [ctm_pkg::DIM_W-1:0] cols,
  input  ctm_pkg::stride_info_t     info,
  input  logic                      s1_go,
  output logic                      s1_valid,
  output ctm_pkg::item_t            s1_item
);

  logic [ctm_pkg::ROW_IDX_W-1:0] row_idx_r, row_idx_nxt;
  logic [ctm_pkg::COL_IDX_W-1:0] col_idx_r, col_idx_nxt;
  logic [ctm_pkg::STRIDE_W-1:0]  row_ph_r, row_ph_nxt;
  logic [ctm_pkg::STRIDE_W-1:0]  col_ph_r, col_ph_nxt;
  logic [ctm_pkg::STRIDE_W-1:0]  stride_r, stride_nxt;
  logic [ctm_pkg::STRIDE_W-1:0]  denom_r, denom_nxt;
  logic                          s1_valid_r, s1_valid_nxt;
  ctm_pkg::item_t                item_r, item_nxt;

  logic                          start;
  logic                          acc;
  logic [ctm_pkg::STRIDE_W-1:0]  stride_use;
  logic [ctm_pkg::STRIDE_W-1:0]  den_use;
  logic [ctm_pkg::STRIDE_W-1:0]  rp;
  logic [ctm_pkg::STRIDE_W-1:0]  cp;
  logic [ctm_pkg::STRIDE_W-1:0]  rp_next;
  logic [ctm_pkg::STRIDE_W-1:0]  cp_next;
  logic [ctm_pkg::STRIDE_W:0]    rp_inc;
  logic [ctm_pkg::STRIDE_W:0]    cp_inc;
  logic                          col_wrap;
  logic                          row_wrap;

  assign start      = (row_idx_r == '0) && (col_idx_r == '0);
  assign in_ready   = (!s1_valid_r || s1_go) && !(start && info.busy);
  assign acc        = in_valid && in_ready;
  assign stride_use = start ? info.stride : stride_r;
  assign den_use    = start ? info.denom : denom_r;
  assign rp         = start ? '0 : row_ph_r;
  assign cp         = start ? '0 : col_ph_r;
  assign rp_inc     = {1'b0, rp} + (ctm_pkg::STRIDE_W + 1)'(1);
  assign cp_inc     = {1'b0, cp} + (ctm_pkg::STRIDE_W + 1)'(1);
  assign rp_next    = (rp_inc >= {1'b0, stride_use}) ? '0 : rp_inc[ctm_pkg::STRIDE_W-1:0];
  assign cp_next    = (cp_inc >= {1'b0, stride_use}) ? '0 : cp_inc[ctm_pkg::STRIDE_W-1:0];
  assign col_wrap   = (ctm_pkg::DIM_W'(col_idx_r) + ctm_pkg::DIM_W'(1)) >= cols;
  assign row_wrap   = (ctm_pkg::DIM_W'(row_idx_r) + ctm_pkg::DIM_W'(1)) >= rows;

  always_comb begin
    row_idx_nxt  = row_idx_r;
    col_idx_nxt  = col_idx_r;
    row_ph_nxt   = row_ph_r;
    col_ph_nxt   = col_ph_r;
    stride_nxt   = stride_r;
    denom_nxt    = denom_r;
    item_nxt     = item_r;
    s1_valid_nxt = s1_go ? 1'b0 : s1_valid_r;
    if (acc) begin
      s1_valid_nxt    = 1'b1;
      stride_nxt      = stride_use;
      denom_nxt       = den_use;
      item_nxt.pix    = in_data;
      item_nxt.sample = (rp == '0) && (cp == '0);
      item_nxt.last   = col_wrap && row_wrap;
      item_nxt.denom  = den_use;
      if (col_wrap) begin
        col_idx_nxt = '0;
        col_ph_nxt  = '0;
        if (row_wrap) begin
          row_idx_nxt = '0;
          row_ph_nxt  = '0;
        end else begin
          row_idx_nxt = row_idx_r + ctm_pkg::ROW_IDX_W'(1);
          row_ph_nxt  = rp_next;
        end
      end else begin
        col_idx_nxt = col_idx_r + ctm_pkg::COL_IDX_W'(1);
        col_ph_nxt  = cp_next;
        row_ph_nxt  = rp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_idx_r  <= '0;
      col_idx_r  <= '0;
      row_ph_r   <= '0;
      col_ph_r   <= '0;
      stride_r   <= ctm_pkg::STRIDE_W'(1);
      denom_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      row_idx_r  <= row_idx_nxt;
      col_idx_r  <= col_idx_nxt;
      row_ph_r   <= row_ph_nxt;
      col_ph_r   <= col_ph_nxt;
      stride_r   <= stride_nxt;
      denom_r    <= denom_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = item_r;

endmodule

// ===== design/ctm_match.sv =====
// Color compare, match accumulator and output register.
`timescale 1ns / 1ps
module ctm_match (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s1_valid,
  input  ctm_pkg::item_t            s1_item,
  input  ctm_pkg::color_set_t       colors,
  input  logic [ctm_pkg::CNT_W-1:0] ncol,
  input  logic [ctm_pkg::TOL_W-1:0] tol,
  output logic                      s1_go,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ctm_pkg::res_t             out_data
);

  localparam logic [ctm_pkg::MATCH_W-1:0] MATCH_MAX = '1;

  logic [ctm_pkg::MATCH_W-1:0]    total_r, total_nxt;
  logic                           out_valid_r, out_valid_nxt;
  ctm_pkg::res_t                  out_r, out_nxt;

  logic [ctm_pkg::NUM_COLORS-1:0] hit;
  logic [ctm_pkg::CNT_W-1:0]      hits;
  logic [ctm_pkg::MATCH_W:0]      sum;
  logic [ctm_pkg::MATCH_W-1:0]    sum_sat;
  logic [ctm_pkg::MATCH_W-1:0]    total_with;

  always_comb begin
    for (int c = 0; c < ctm_pkg::NUM_COLORS; c++) begin
      hit[c] = (ctm_pkg::CNT_W'(c) < ncol) &&
               ctm_pkg::channel_ok(colors[c][23:16], s1_item.pix.red, tol) &&
               ctm_pkg::channel_ok(colors[c][15:8], s1_item.pix.green, tol) &&
               ctm_pkg::channel_ok(colors[c][7:0], s1_item.pix.blue, tol);
    end
  end

  assign hits       = ctm_pkg::CNT_W'($countones(hit));
  assign sum        = {1'b0, total_r} + (ctm_pkg::MATCH_W + 1)'(hits);
  assign sum_sat    = sum[ctm_pkg::MATCH_W] ? MATCH_MAX : sum[ctm_pkg::MATCH_W-1:0];
  assign total_with = s1_item.sample ? sum_sat : total_r;
  assign s1_go      = s1_valid && (!s1_item.last || !out_valid_r || out_ready);

  always_comb begin
    total_nxt     = total_r;
    out_nxt       = out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (s1_go) begin
      if (s1_item.last) begin
        total_nxt                  = '0;
        out_nxt.match_count        = total_with;
        out_nxt.sample_denominator = s1_item.denom;
        out_valid_nxt              = 1'b1;
      end else begin
        total_nxt = total_with;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/color_tolerance_match_counter_unit.sv =====
// Top level of the color tolerance match counter: configuration registers and datapath.
`timescale 1ns / 1ps
// Pixels enter in raster order, one per clock while in_ready is high, and each
// passes from request to result register through an input register, then the
// color compare and the match accumulator. One result request (match count and
// denominator) follows the last pixel of each image. The stride and denominator
// come from a multiply and two bit-serial divisions (only the second when
// sample_budget is 0) that run after reset and after any write to sample_budget,
// image_rows or image_cols; only the first pixel of an image waits on that
// engine, so in steady state one pixel is taken every cycle. A stalled result
// holds the input only once the last pixel of the next image reaches the
// input register.
module color_tolerance_match_counter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ctm_pkg::pix_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ctm_pkg::res_t                 out_data,
  input  logic                          cfg_we,
  input  logic [ctm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctm_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [2*ctm_pkg::COLOR_W-1:0] pair_a_r, pair_b_r;
  logic [ctm_pkg::COLOR_W-1:0]   last_r;
  logic [ctm_pkg::ACT_W-1:0]     active_r;
  logic [ctm_pkg::TOL_W-1:0]     tol_r;
  logic [ctm_pkg::BUDGET_W-1:0]  budget_r;
  logic [ctm_pkg::DIM_W-1:0]     rows_r, cols_r;

  logic [ctm_pkg::DIM_W-1:0]     rows_c, cols_c;
  logic [ctm_pkg::CNT_W-1:0]     ncol;
  logic                          restart;
  ctm_pkg::color_set_t           colors;
  ctm_pkg::stride_info_t         info;
  ctm_pkg::item_t                s1_item;
  logic                          s1_valid;
  logic                          s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_a_r <= '0;
      pair_b_r <= '0;
      last_r   <= '0;
      active_r <= ctm_pkg::ACT_W'(1);
      tol_r    <= ctm_pkg::TOL_W'(16);
      budget_r <= '0;
      rows_r   <= ctm_pkg::DIM_W'(1);
      cols_r   <= ctm_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      case (ctm_pkg::cfg_reg_e'(cfg_index))
        ctm_pkg::REG_PAIR_A: pair_a_r <= cfg_wdata[2*ctm_pkg::COLOR_W-1:0];
        ctm_pkg::REG_PAIR_B: pair_b_r <= cfg_wdata[2*ctm_pkg::COLOR_W-1:0];
        ctm_pkg::REG_LAST:   last_r   <= cfg_wdata[ctm_pkg::COLOR_W-1:0];
        ctm_pkg::REG_ACTIVE: active_r <= cfg_wdata[ctm_pkg::ACT_W-1:0];
        ctm_pkg::REG_TOL:    tol_r    <= cfg_wdata[ctm_pkg::TOL_W-1:0];
        ctm_pkg::REG_BUDGET: budget_r <= cfg_wdata[ctm_pkg::BUDGET_W-1:0];
        ctm_pkg::REG_ROWS:   rows_r   <= cfg_wdata[ctm_pkg::DIM_W-1:0];
        ctm_pkg::REG_COLS:   cols_r   <= cfg_wdata[ctm_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign restart = cfg_we &&
                   ((ctm_pkg::cfg_reg_e'(cfg_index) == ctm_pkg::REG_BUDGET) ||
                    (ctm_pkg::cfg_reg_e'(cfg_index) == ctm_pkg::REG_ROWS) ||
                    (ctm_pkg::cfg_reg_e'(cfg_index) == ctm_pkg::REG_COLS));

  // size and color count clamps; zero acts as one
  assign rows_c = (rows_r == '0) ? ctm_pkg::DIM_W'(1) :
                  (rows_r > ctm_pkg::DIM_W'(ctm_pkg::MAX_ROWS)) ?
                  ctm_pkg::DIM_W'(ctm_pkg::MAX_ROWS) : rows_r;
  assign cols_c = (cols_r == '0) ? ctm_pkg::DIM_W'(1) :
                  (cols_r > ctm_pkg::DIM_W'(ctm_pkg::MAX_COLS)) ?
                  ctm_pkg::DIM_W'(ctm_pkg::MAX_COLS) : cols_r;
  assign ncol   = (active_r == '0) ? ctm_pkg::CNT_W'(1) :
                  (ctm_pkg::CNT_W'(active_r) > ctm_pkg::CNT_W'(ctm_pkg::NUM_COLORS)) ?
                  ctm_pkg::CNT_W'(ctm_pkg::NUM_COLORS) : ctm_pkg::CNT_W'(active_r);

  assign colors = {last_r, pair_b_r, pair_a_r};

  ctm_stride u_stride (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .rows    (rows_c),
    .cols    (cols_c),
    .budget  (budget_r),
    .info    (info)
  );

  ctm_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .rows     (rows_c),
    .cols     (cols_c),
    .info     (info),
    .s1_go    (s1_go),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ctm_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .colors    (colors),
    .ncol      (ncol),
    .tol       (tol_r),
    .s1_go     (s1_go),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
